// ===== hw/rtl/lpc_pkg.sv =====
package lpc_pkg;

   // sensor array and field widths
   localparam int NumSensors = 8;
   localparam int SensorIdxW = 3;
   localparam int TimeW      = 11;
   localparam int CsrIdxW    = 4;
   localparam int PosW       = 16;

   // saturation point of a discharge time, in ticks
   localparam logic [TimeW-1:0] TimeoutCount = 11'd2000;

   // fixed point: weights are unsigned q1.12
   localparam int QFrac  = 12;
   localparam int WeightW = QFrac + 1;
   localparam int WsumW  = 16;
   localparam int IsumW  = 18;
   localparam int ProdW  = 18;

   // shared divider geometry
   localparam int DivNumW   = 31;
   localparam int DivDenW   = 17;
   localparam int DivQW     = 16;
   localparam int DivCntW   = 3;
   localparam int QueueDepth = 2;

   localparam logic [ProdW-1:0]  PctScale   = 18'd100;
   localparam logic [WsumW-1:0]  HalfWeight = 16'd2048;
   localparam logic signed [PosW-1:0] CenterQ   = 16'sd14336;
   localparam logic signed [PosW-1:0] LostPos   = 16'sd16384;
   localparam logic signed [PosW-1:0] NearZeroQ = 16'sd820;

   // one classified scan, ready for the weight divisions
   typedef struct packed {
      logic [NumSensors-1:0][TimeW-1:0] num;
      logic [NumSensors-1:0][TimeW-1:0] den;
   } lpc_job_type;

   typedef struct packed {
      logic busy;
      logic done;
   } lpc_div_stat_type;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_WEIGHT = 4'b0010,
      S_CENT   = 4'b0100,
      S_EMIT   = 4'b1000
   } lpc_state_type;

endpackage

// ===== hw/rtl/lpc_req_if.sv =====
interface lpc_req_if;
   import lpc_pkg::*;

   logic             valid;
   logic             ready;
   logic [TimeW-1:0] time_0;
   logic [TimeW-1:0] time_1;
   logic [TimeW-1:0] time_2;
   logic [TimeW-1:0] time_3;
   logic [TimeW-1:0] time_4;
   logic [TimeW-1:0] time_5;
   logic [TimeW-1:0] time_6;
   logic [TimeW-1:0] time_7;

   modport source (
      output valid, time_0, time_1, time_2, time_3, time_4, time_5, time_6, time_7,
      input  ready
   );

   modport sink (
      input  valid, time_0, time_1, time_2, time_3, time_4, time_5, time_6, time_7,
      output ready
   );

endinterface

// ===== hw/rtl/lpc_rsp_if.sv =====
interface lpc_rsp_if;
   import lpc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic signed [PosW-1:0] position;
   logic                   line_lost;

   modport source (
      output valid, position, line_lost,
      input  ready
   );

   modport sink (
      input  valid, position, line_lost,
      output ready
   );

endinterface

// ===== hw/rtl/lpc_front.sv =====
module lpc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [lpc_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [lpc_pkg::TimeW-1:0]     csr_wdata,
   lpc_req_if.sink                       req_bus,
   input  logic                          q_full,
   output logic                          q_push,
   output lpc_pkg::lpc_job_type          q_job
);
   import lpc_pkg::*;

   logic [NumSensors-1:0][TimeW-1:0] min_ff;
   logic [NumSensors-1:0][TimeW-1:0] min_in;
   logic [NumSensors-1:0][TimeW-1:0] t_raw;
   logic [TimeW-1:0]                 t_c;
   logic [TimeW-1:0]                 num;
   logic [TimeW-1:0]                 den;
   logic                             zero;

   // calibration minimums
   always_comb begin
      min_in = min_ff;
      if (csr_we && (csr_index < CsrIdxW'(NumSensors))) begin
         min_in[csr_index[SensorIdxW-1:0]] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0;
      end else begin
         min_ff <= min_in;
      end
   end

   assign req_bus.ready = !q_full;
   assign q_push        = req_bus.valid && !q_full;

   assign t_raw[0] = req_bus.time_0;
   assign t_raw[1] = req_bus.time_1;
   assign t_raw[2] = req_bus.time_2;
   assign t_raw[3] = req_bus.time_3;
   assign t_raw[4] = req_bus.time_4;
   assign t_raw[5] = req_bus.time_5;
   assign t_raw[6] = req_bus.time_6;
   assign t_raw[7] = req_bus.time_7;

   // clamp, offset and drop weights under one percent
   always_comb begin
      q_job = '0;
      t_c   = '0;
      num   = '0;
      den   = '0;
      zero  = 1'b0;
      for (int i = 0; i < NumSensors; i++) begin
         t_c  = (t_raw[i] > TimeoutCount) ? TimeoutCount : t_raw[i];
         num  = t_c - min_ff[i];
         den  = TimeoutCount - min_ff[i];
         zero = (min_ff[i] >= TimeoutCount) || (t_c <= min_ff[i]) ||
                ((ProdW'(num) * PctScale) < ProdW'(den));
         q_job.num[i] = zero ? '0 : num;
         q_job.den[i] = zero ? TimeW'(1) : den;
      end
   end

endmodule

// ===== hw/rtl/lpc_queue.sv =====
module lpc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  lpc_pkg::lpc_job_type push_job,
   input  logic                 pop,
   output lpc_pkg::lpc_job_type head_job,
   output logic                 full,
   output logic                 not_empty
);
   import lpc_pkg::*;

   lpc_job_type slot_ff [QueueDepth];
   logic [$clog2(QueueDepth)-1:0] wr_ptr_ff;
   logic [$clog2(QueueDepth)-1:0] rd_ptr_ff;
   logic [$clog2(QueueDepth):0]   cnt_ff;
   logic [$clog2(QueueDepth):0]   cnt_in;

   assign full      = (cnt_ff == ($clog2(QueueDepth)+1)'(QueueDepth));
   assign not_empty = (cnt_ff != '0);
   assign head_job  = slot_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("word pushed into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop)
      else $error("pop from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= ($clog2(QueueDepth)+1)'(QueueDepth))
      else $error("queue count out of range");
`endif

endmodule

// ===== hw/rtl/lpc_div.sv =====
module lpc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          wide,
   input  logic [lpc_pkg::DivNumW-1:0]   dividend,
   input  logic [lpc_pkg::DivDenW-1:0]   divisor,
   output logic [lpc_pkg::DivQW-1:0]     quotient,
   output lpc_pkg::lpc_div_stat_type     stat
);
   import lpc_pkg::*;

   logic [DivDenW-1:0] rem_ff, rem_in;
   logic [DivQW-1:0]   shf_ff, shf_in;
   logic [DivQW-1:0]   quo_ff, quo_in;
   logic [DivDenW-1:0] dsr_ff;
   logic [DivCntW-1:0] cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [DivDenW:0]   trial;
   logic               hit;

   // two restoring steps per cycle
   always_comb begin
      rem_in = rem_ff;
      shf_in = shf_ff;
      quo_in = quo_ff;
      trial  = '0;
      hit    = 1'b0;
      for (int i = 0; i < 2; i++) begin
         trial = {rem_in, shf_in[DivQW-1]};
         hit   = (trial >= {1'b0, dsr_ff});
         if (hit) begin
            trial = trial - {1'b0, dsr_ff};
         end
         rem_in = trial[DivDenW-1:0];
         shf_in = {shf_in[DivQW-2:0], 1'b0};
         quo_in = {quo_in[DivQW-2:0], hit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= wide ? DivCntW'(DivQW/2 - 1) : DivCntW'(DivQW/2 - 2);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   // narrow mode yields 14 quotient bits, wide mode 16
   always_ff @(posedge clock) begin
      if (start) begin
         dsr_ff <= divisor;
         quo_ff <= '0;
         if (wide) begin
            rem_ff <= DivDenW'(dividend[DivNumW-1:DivQW]);
            shf_ff <= dividend[DivQW-1:0];
         end else begin
            rem_ff <= dividend[DivNumW-1:DivQW-2];
            shf_ff <= {dividend[DivQW-3:0], 2'b00};
         end
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         shf_ff <= shf_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== hw/rtl/lpc_back.sv =====
module lpc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  lpc_pkg::lpc_job_type job,
   output logic                 job_pop,
   lpc_rsp_if.source            rsp_bus
);
   import lpc_pkg::*;

   lpc_state_type              state_ff, state_in;
   lpc_job_type                job_ff;
   logic [SensorIdxW-1:0]      idx_ff;
   logic [WsumW-1:0]           wsum_ff, wsum_in;
   logic [IsumW-1:0]           isum_ff, isum_in;
   logic                       go_ff;
   logic signed [PosW-1:0]     res_pos_ff, res_pos_in;
   logic                       res_lost_ff;
   logic                       out_valid_ff;
   logic signed [PosW-1:0]     out_pos_ff;
   logic                       out_lost_ff;
   logic signed [PosW-1:0]     last_pos_ff;
   logic                       out_load;

   logic                       div_wide;
   logic [DivNumW-1:0]         div_dividend;
   logic [DivDenW-1:0]         div_divisor;
   logic [DivQW-1:0]           div_quo;
   lpc_div_stat_type           div_stat;
   logic [WeightW-1:0]         weight;
   logic signed [PosW-1:0]     lost_pos;

   lpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (go_ff),
      .wide     (div_wide),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   // weight: num * 4096 / den; centroid: (isum * 8192 + wsum) / (2 * wsum)
   always_comb begin
      div_wide = (state_ff == S_CENT);
      if (div_wide) begin
         div_dividend = {isum_ff, (QFrac+1)'(0)} + DivNumW'(wsum_ff);
         div_divisor  = {wsum_ff, 1'b0};
      end else begin
         div_dividend = DivNumW'({job_ff.num[idx_ff], QFrac'(0)});
         div_divisor  = DivDenW'(job_ff.den[idx_ff]);
      end
   end

   assign weight  = div_quo[WeightW-1:0];
   assign wsum_in = wsum_ff + WsumW'(weight);
   assign isum_in = isum_ff + (IsumW'(idx_ff) * IsumW'(weight));

   always_comb begin
      if (last_pos_ff >= NearZeroQ) begin
         lost_pos = LostPos;
      end else if (last_pos_ff <= -NearZeroQ) begin
         lost_pos = -LostPos;
      end else begin
         lost_pos = '0;
      end
   end

   assign res_pos_in = CenterQ - $signed(div_quo);
   assign out_load   = (state_ff == S_EMIT) && (!out_valid_ff || rsp_bus.ready);
   assign job_pop    = (state_ff == S_IDLE) && job_valid;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               state_in = S_WEIGHT;
            end
         end
         S_WEIGHT: begin
            if (div_stat.done && (idx_ff == SensorIdxW'(NumSensors-1))) begin
               state_in = (wsum_in < HalfWeight) ? S_EMIT : S_CENT;
            end
         end
         S_CENT: begin
            if (div_stat.done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         go_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         last_pos_ff  <= '0;
      end else begin
         state_ff <= state_in;
         go_ff    <= 1'b0;
         if (job_pop) begin
            go_ff <= 1'b1;
         end
         if ((state_ff == S_WEIGHT) && div_stat.done) begin
            if (idx_ff != SensorIdxW'(NumSensors-1)) begin
               go_ff <= 1'b1;
            end else if (wsum_in >= HalfWeight) begin
               go_ff <= 1'b1;
            end
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
            last_pos_ff  <= res_pos_ff;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff  <= job;
         idx_ff  <= '0;
         wsum_ff <= '0;
         isum_ff <= '0;
      end
      if ((state_ff == S_WEIGHT) && div_stat.done) begin
         idx_ff  <= idx_ff + 1'b1;
         wsum_ff <= wsum_in;
         isum_ff <= isum_in;
         if ((idx_ff == SensorIdxW'(NumSensors-1)) && (wsum_in < HalfWeight)) begin
            res_pos_ff  <= lost_pos;
            res_lost_ff <= 1'b1;
         end
      end
      if ((state_ff == S_CENT) && div_stat.done) begin
         res_pos_ff  <= res_pos_in;
         res_lost_ff <= 1'b0;
      end
      if (out_load) begin
         out_pos_ff  <= res_pos_ff;
         out_lost_ff <= res_lost_ff;
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.position  = out_pos_ff;
   assign rsp_bus.line_lost = out_lost_ff;

`ifndef SYNTHESIS
   a_lost_value: assert property (@(posedge clock) disable iff (reset)
      (out_load && res_lost_ff) |->
         (res_pos_ff == LostPos || res_pos_ff == -LostPos || res_pos_ff == '0))
      else $error("lost-line word with unexpected position");
   a_centroid_range: assert property (@(posedge clock) disable iff (reset)
      (out_load && !res_lost_ff) |->
         (res_pos_ff <= CenterQ && res_pos_ff >= -CenterQ))
      else $error("centroid position out of range");
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_WEIGHT || state_ff == S_CENT))
      else $error("divider finished outside a division state");
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      go_ff |-> !div_stat.busy)
      else $error("divider started while busy");
   a_last_tracks: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (last_pos_ff == rsp_bus.position))
      else $error("held position differs from the word sent");
`endif

endmodule

// ===== hw/rtl/line_position_centroid.sv =====
// channel   dir  handshake            payload
// req_bus   in   valid / ready        time_0 .. time_7, 11 bit ticks
// rsp_bus   out  valid / ready        position (q.12 signed), line_lost
// csr_*     in   csr_we, no handshake csr_index 0..7 -> min_level_i, csr_wdata
//
// a word holds the back end through one queue pop, eight weight divisions (start,
// 7 radix-4 steps, done), one centroid division of 8 steps that is skipped when the
// line is lost, and one load of the output register
// reset clears the calibration minimums, the held position and all valid flags
// the front takes a word whenever the two-entry queue has room; a stalled
// result sits in the output register while the next word is already divided
module line_position_centroid (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [lpc_pkg::CsrIdxW-1:0] csr_index,
   input  logic [lpc_pkg::TimeW-1:0]   csr_wdata,
   lpc_req_if.sink                     req_bus,
   lpc_rsp_if.source                   rsp_bus
);
   import lpc_pkg::*;

   // front to back queue
   lpc_job_type push_job;
   lpc_job_type head_job;
   logic        q_push;
   logic        q_pop;
   logic        q_full;
   logic        q_not_empty;

   // clamps the times, applies calibration and flags dead sensors
   lpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   // lets the front keep accepting while the divider is busy
   lpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .pop       (q_pop),
      .head_job  (head_job),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   // weights, centroid, lost-line fallback and the output register
   lpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_not_empty),
      .job       (head_job),
      .job_pop   (q_pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== test/tb_line_position_centroid.sv =====
`timescale 1ns / 1ps

module tb_line_position_centroid;
   import lpc_pkg::*;

   // cycles allowed after the last word for the back end to go quiet
   localparam int SettleCycles = 200;
   // cycles with no handshake on either channel before the run is abandoned
   localparam int StallLimit   = 5000;
   localparam int unsigned QOne = 1 << QFrac;

   // one scan, sensor 0 in the low slice
   typedef logic [NumSensors-1:0][TimeW-1:0] scan_type;

   typedef struct packed {
      logic signed [PosW-1:0] position;
      logic                   line_lost;
   } centroid_type;

   // how the calibration minimums are chosen for one phase
   typedef enum int {
      CAL_ZERO,
      CAL_LOW,
      CAL_ANY,
      CAL_TIMEOUT,
      CAL_NEAR_TIMEOUT,
      CAL_EXTREME
   } cal_mode_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CsrIdxW-1:0]   csr_index;
   logic [TimeW-1:0]     csr_wdata;

   lpc_req_if req_bus ();
   lpc_rsp_if rsp_bus ();

   line_position_centroid DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   always #10 clock = ~clock;

   // predictor state: our own copy of the calibration and the held position
   logic [TimeW-1:0] cal_min [NumSensors];
   int               held_position = 0;

   scan_type     scan_queue [$];        // scans waiting for the driver
   centroid_type centroid_expect [$];   // predicted results in arrival order
   int           words_queued = 0;
   int           words_taken  = 0;
   int           mismatches   = 0;

   // handshake bookkeeping for driver, receiver and watchdog
   logic        req_taken = 1'b0;
   int unsigned send_gap = 0;
   int unsigned recv_stall = 0;
   bit          send_calm = 1'b0;
   bit          recv_calm = 1'b0;
   int          quiet_cycles = 0;

   // normalized q1.12 weight of one sensor
   function automatic int unsigned sensor_weight(logic [TimeW-1:0] t_raw,
                                                 logic [TimeW-1:0] lo);
      int unsigned t, num, den;
      t = (t_raw > TimeoutCount) ? TimeoutCount : t_raw;   // saturate at timeout
      if (lo >= TimeoutCount || t <= lo) return 0;
      num = t - lo;
      den = TimeoutCount - lo;
      if (num * 100 < den) return 0;                       // below one percent
      return (num * QOne) / den;
   endfunction

   // centroid of one scan; also advances the held position
   function automatic centroid_type predict_centroid(scan_type s);
      centroid_type r;
      int unsigned  w, wsum, isum, q;
      int           pos;
      wsum = 0;
      isum = 0;
      for (int i = 0; i < NumSensors; i++) begin
         w = sensor_weight(s[i], cal_min[i]);
         wsum += w;
         isum += i * w;
      end
      if (wsum < HalfWeight) begin
         // line lost: park at the side it was last seen on
         r.line_lost = 1'b1;
         if (held_position >= NearZeroQ) pos = LostPos;
         else if (held_position <= -NearZeroQ) pos = -LostPos;
         else pos = 0;
      end else begin
         // rounded to nearest, ties upward
         q = (isum * 2 * QOne + wsum) / (2 * wsum);
         r.line_lost = 1'b0;
         pos = CenterQ - int'(q);
      end
      held_position = pos;
      r.position = PosW'(pos);
      return r;
   endfunction

   // mostly short gaps, a few long ones; none at all while calm
   function automatic int unsigned pick_gap(bit calm);
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 4);
      if (r < 97) return $urandom_range(5, 20);
      return $urandom_range(30, 90);
   endfunction

   // random scan shaped by the current calibration
   function automatic scan_type random_scan();
      scan_type    s;
      int unsigned kind;
      int          lo, span, t;
      real         c, spread, f;
      kind   = $urandom_range(0, 99);
      c      = $urandom_range(0, 7000) / 1000.0;
      spread = $urandom_range(400, 2500) / 1000.0;
      for (int i = 0; i < NumSensors; i++) begin
         lo   = cal_min[i];
         span = int'(TimeoutCount) - lo;
         if (span < 0) span = 0;
         if (kind < 50) begin
            // a line somewhere under the array, tent profile plus noise
            f = 1.0 - ((i > c) ? (i - c) : (c - i)) / spread;
            if (f < 0.0) f = 0.0;
            t = lo + int'(f * span) + int'($urandom_range(0, 40)) - 20;
            if (f > 0.9 && $urandom_range(0, 1) == 1)
               t = int'(TimeoutCount) + int'($urandom_range(0, 47));
         end else if (kind < 65) begin
            // bright floor only, every weight at most a third
            t = lo + int'($urandom_range(0, span / 3));
         end else if (kind < 80) begin
            // corners: around the minimum, the one percent edge, half span, timeout and full scale
            case ($urandom_range(0, 8))
               0: t = lo - 1;
               1: t = lo;
               2: t = lo + 1;
               3: t = lo + (span + 99) / 100;
               4: t = lo + (span + 99) / 100 - 1;
               5: t = lo + span / 2;
               6: t = int'(TimeoutCount) - 1;
               7: t = int'(TimeoutCount) + 1;
               default: t = 2047;
            endcase
         end else begin
            t = $urandom_range(0, 2047);
         end
         if (t < 0) t = 0;
         if (t > 2047) t = 2047;
         s[i] = t[TimeW-1:0];
      end
      return s;
   endfunction

   task automatic push_scan(scan_type s);
      scan_queue.push_back(s);
      words_queued++;
   endtask

   // one register write; indexes past the last sensor are dropped by the block
   task automatic write_min(logic [CsrIdxW-1:0] idx, logic [TimeW-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx < NumSensors) cal_min[idx[SensorIdxW-1:0]] = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic calibrate(cal_mode_type mode);
      logic [TimeW-1:0] value;
      for (int i = 0; i < NumSensors; i++) begin
         case (mode)
            CAL_ZERO:         value = '0;
            CAL_LOW:          value = TimeW'($urandom_range(0, 400));
            CAL_TIMEOUT:      value = TimeoutCount;
            CAL_NEAR_TIMEOUT: value = TimeoutCount - 11'd1;
            CAL_EXTREME: begin
               case ($urandom_range(0, 4))
                  0:       value = '0;
                  1:       value = 11'd1;
                  2:       value = 11'd1000;
                  3:       value = TimeoutCount - 11'd1;
                  default: value = TimeoutCount;
               endcase
            end
            default:          value = TimeW'($urandom_range(0, 2000));
         endcase
         write_min(CsrIdxW'(i), value);
      end
      // stray write to an unmapped index
      write_min(CsrIdxW'(NumSensors + $urandom_range(0, 7)),
                TimeW'($urandom_range(0, 2047)));
   endtask

   // hold off until every word is back, then let the back end go quiet
   task automatic wait_drained();
      do @(negedge clock);
      while (words_taken != words_queued || centroid_expect.size() != 0);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic run_phase(cal_mode_type mode, int count);
      calibrate(mode);
      for (int n = 0; n < count; n++) push_scan(random_scan());
      wait_drained();
   endtask

   // driver: new word at the falling edge once the last one was taken
   always @(negedge clock) begin
      scan_type next_scan;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (send_gap != 0) begin
            req_bus.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (scan_queue.size() != 0) begin
            next_scan = scan_queue.pop_front();
            req_bus.time_0 <= next_scan[0];
            req_bus.time_1 <= next_scan[1];
            req_bus.time_2 <= next_scan[2];
            req_bus.time_3 <= next_scan[3];
            req_bus.time_4 <= next_scan[4];
            req_bus.time_5 <= next_scan[5];
            req_bus.time_6 <= next_scan[6];
            req_bus.time_7 <= next_scan[7];
            req_bus.valid  <= 1'b1;
            send_gap <= pick_gap(send_calm);
            // switch between idling and back-to-back stretches now and then
            if ($urandom_range(0, 63) == 0) send_calm <= !send_calm;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls on the result side
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (recv_stall != 0) begin
         rsp_bus.ready <= 1'b0;
         recv_stall <= recv_stall - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         recv_stall <= pick_gap(recv_calm);
         if ($urandom_range(0, 63) == 0) recv_calm <= !recv_calm;
      end
   end

   // monitor: check returned words, then predict for the word just taken
   always @(posedge clock) begin
      centroid_type want;
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (centroid_expect.size() == 0) begin
               $error("unexpected word: position %0d line_lost %0b",
                      $signed(rsp_bus.position), rsp_bus.line_lost);
               mismatches++;
            end else begin
               want = centroid_expect.pop_front();
               if (rsp_bus.position !== want.position) begin
                  $error("position: expected %0d, got %0d",
                         $signed(want.position), $signed(rsp_bus.position));
                  mismatches++;
               end
               if (rsp_bus.line_lost !== want.line_lost) begin
                  $error("line_lost: expected %0b, got %0b",
                         want.line_lost, rsp_bus.line_lost);
                  mismatches++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            centroid_expect.push_back(predict_centroid({req_bus.time_7, req_bus.time_6,
               req_bus.time_5, req_bus.time_4, req_bus.time_3, req_bus.time_2,
               req_bus.time_1, req_bus.time_0}));
            words_taken++;
         end
      end
   end

   // watchdog: no handshake on either side for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("tb_line_position_centroid NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      scan_type s;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_bus.valid  = 1'b0;
      req_bus.time_0 = '0;
      req_bus.time_1 = '0;
      req_bus.time_2 = '0;
      req_bus.time_3 = '0;
      req_bus.time_4 = '0;
      req_bus.time_5 = '0;
      req_bus.time_6 = '0;
      req_bus.time_7 = '0;
      rsp_bus.ready  = 1'b0;
      for (int i = 0; i < NumSensors; i++) cal_min[i] = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed scans, calibration still at reset (all minimums zero)
      s = '0;                                     push_scan(s);   // dark, no history
      s = {NumSensors{11'h7FF}};                  push_scan(s);   // all far past timeout
      s = '0; s[0] = TimeoutCount;                push_scan(s);   // hard left edge
      s = '0;                                     push_scan(s);   // lost after left
      s = '0; s[7] = 11'h7FF;                     push_scan(s);   // hard right edge
      s = '0;                                     push_scan(s);   // lost after right
      s = '0; s[3] = TimeoutCount; s[4] = 11'd856; push_scan(s);  // lands on +0.2
      s = '0;                                     push_scan(s);
      s = '0; s[4] = TimeoutCount; s[3] = 11'd856; push_scan(s);  // lands on -0.2
      s = '0;                                     push_scan(s);
      s = '0; s[3] = TimeoutCount; s[4] = 11'd857; push_scan(s);  // just inside dead band
      s = '0;                                     push_scan(s);   // lost, centered
      s = {NumSensors{11'd19}};                   push_scan(s);   // weights just under 1%
      s = {NumSensors{11'd20}}; s[7] = TimeoutCount;
      push_scan(s);                                               // weights just at 1%
      s = {4{11'h555, 11'h2AA}};                  push_scan(s);   // alternating bit patterns
      s = {4{11'h2AA, 11'h555}};                  push_scan(s);
      s = '0; s[2] = 11'd1000;                    push_scan(s);   // total weight exactly half
      s = '0; s[2] = 11'd999;                     push_scan(s);   // total weight just short
      s = '0; s[6] = 11'd2001; s[5] = 11'd1500;
      push_scan(s);                                               // one time above timeout
      wait_drained();

      // random phases, each under a fresh calibration; each ends fully drained
      run_phase(CAL_LOW,          170);
      run_phase(CAL_ANY,          200);
      run_phase(CAL_TIMEOUT,       60);
      run_phase(CAL_NEAR_TIMEOUT, 100);
      run_phase(CAL_EXTREME,      170);
      run_phase(CAL_ANY,          170);
      run_phase(CAL_ZERO,         160);

      if (mismatches == 0) $display("tb_line_position_centroid OK");
      else $display("tb_line_position_centroid NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/lpc_pkg.sv
hw/rtl/lpc_req_if.sv
hw/rtl/lpc_rsp_if.sv
hw/rtl/lpc_front.sv
hw/rtl/lpc_queue.sv
hw/rtl/lpc_div.sv
hw/rtl/lpc_back.sv
hw/rtl/line_position_centroid.sv
test/tb_line_position_centroid.sv
